/* sv/s2c_pkg.sv */
package s2c_pkg;

  // Port widths
  localparam int SECS_W  = 32;
  localparam int YEAR_W  = 8;
  localparam int MONTH_W = 4;
  localparam int MDAY_W  = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int WDAY_W  = 3;
  localparam int WEEK_W  = 13;

  // Internal widths
  localparam int DAYS_W = 16;  // days since the epoch, below 49711
  localparam int DOE_W  = 16;  // day of the 400-year era, below 54034
  localparam int DOY_W  = 9;   // day of the March-based year, below 366
  localparam int MP_W   = 4;   // March-based month index, 0 to 11
  localparam int YOE_W  = 8;   // year of era, at most 148

  // Pipeline registers between the accept edge and the output register.
  localparam int PIPE_DEPTH = 16;

  // The epoch day sits 4323 days into the era that starts at 2000-03-01.
  localparam logic [DOE_W-1:0]  EPOCH_DOE     = 16'd4323;
  // Days since the epoch at which the day of era reaches the first century.
  localparam logic [DAYS_W-1:0] CENTURY_DAYS  = 16'd32201;
  localparam logic [YOE_W-1:0]  CENTURY_YEARS = 8'd100;
  localparam logic [MP_W-1:0]   MP_JANUARY    = 4'd10;

  // First day of each March-based month within the year, (153 * mp + 2) / 5.
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

/* sv/s2c_dly.sv */
module s2c_dly #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [N];

  always_ff @(posedge clk) begin
    tap_r[0] <= d;
    for (int i = 1; i < N; i++) begin
      tap_r[i] <= tap_r[i-1];
    end
  end

  assign q = tap_r[N-1];

endmodule

/* sv/s2c_cdiv.sv */
module s2c_cdiv #(
  parameter int W  = 16,
  parameter int D  = 7,
  parameter int QW = 13
) (
  input  logic                    clk,
  input  logic [W-1:0]            x,
  output logic [QW-1:0]           q,
  output logic [$clog2(D)-1:0]    r
);

  // Quotient estimate from a truncated reciprocal is exact or one low;
  // the last stage fixes it with one compare and subtract.
  localparam int K  = W;
  localparam int MW = K - $clog2(D + 1) + 1;
  localparam int PW = W + MW;
  localparam int RW = $clog2(D);
  localparam longint unsigned RECIP = (64'd1 << K) / D;
  localparam logic [MW-1:0] RECIP_W = MW'(RECIP);
  localparam logic [W-1:0]  DIV_W   = W'(D);
  localparam logic [RW:0]   DIV_R   = (RW+1)'(D);

  logic [PW-1:0] prod_r;
  logic [W-1:0]  x_r;
  logic [QW-1:0] qe_r;
  logic [RW:0]   re_r;
  logic [QW-1:0] q_r;
  logic [RW-1:0] r_r;

  logic [QW-1:0] qe;
  logic [W-1:0]  qd;
  logic          over;

  assign qe   = QW'(prod_r >> K);
  assign qd   = W'(qe) * DIV_W;
  assign over = (re_r >= DIV_R);

  always_ff @(posedge clk) begin
    prod_r <= PW'(x) * PW'(RECIP_W);
    x_r    <= x;
    qe_r   <= qe;
    re_r   <= (RW+1)'(x_r - qd);
    q_r    <= over ? qe_r + 1'b1 : qe_r;
    r_r    <= RW'(over ? re_r - DIV_R : re_r);
  end

  assign q = q_r;
  assign r = r_r;

endmodule

/* sv/seconds_to_calendar_fields_unit.sv */
// Seconds-to-calendar converter.
//
// A beat on the input channel carries a count of seconds since
// 2012-01-01 00:00:00, a Sunday. It is taken at a rising edge where start is
// high and busy is low. busy is always low, so a new beat can be taken at
// every edge: the unit sustains one beat per clock cycle.
//
// Each result beat (year minus 2000, month, day, hour, minute, second,
// weekday and whole weeks since the epoch) shows on the out_ ports for one
// cycle with out_valid high. Results come out for every beat, in order. The
// receiver cannot hold results off, so the pipeline never stalls and no
// buffering is needed.
//
// Latency is set by the date path's constant divisions: seconds to days,
// day of era over 1460, day count to years over 365, day of year to month
// over 153; each a three-stage reciprocal multiply with a correction step.
// The time-of-day and week paths run in parallel and are delayed to match.
//
// A synchronous, active-low reset clears the valid bits; beats in flight are
// dropped and no result is shown until new beats have worked through.
module seconds_to_calendar_fields_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [s2c_pkg::SECS_W-1:0]    in_seconds_since_epoch,
  output logic                          out_valid,
  output logic [s2c_pkg::YEAR_W-1:0]    out_year_since_2000,
  output logic [s2c_pkg::MONTH_W-1:0]   out_month,
  output logic [s2c_pkg::MDAY_W-1:0]    out_day_of_month,
  output logic [s2c_pkg::HOUR_W-1:0]    out_hour,
  output logic [s2c_pkg::MIN_W-1:0]     out_minute,
  output logic [s2c_pkg::SEC_W-1:0]     out_second,
  output logic [s2c_pkg::WDAY_W-1:0]    out_weekday,
  output logic [s2c_pkg::WEEK_W-1:0]    out_week_index
);

  import s2c_pkg::*;

  // Valid bits travel alongside the data, one per pipeline register level.
  logic [PIPE_DEPTH-1:0] v_r;
  logic [PIPE_DEPTH-1:0] v_nxt;
  logic                  accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign v_nxt  = {v_r[PIPE_DEPTH-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Seconds to days. 86400 is 675 times 128, so the low seven bits pass by
  // and the rest is divided by 675.
  logic [DAYS_W-1:0] days3;
  logic [9:0]        rday3;
  logic [6:0]        lo7_3;
  logic [16:0]       rem3;

  s2c_cdiv #(.W(25), .D(675), .QW(DAYS_W)) u_div_day (
    .clk (clk),
    .x   (in_seconds_since_epoch[31:7]),
    .q   (days3),
    .r   (rday3)
  );

  s2c_dly #(.W(7), .N(3)) u_dly_lo7 (
    .clk (clk),
    .d   (in_seconds_since_epoch[6:0]),
    .q   (lo7_3)
  );

  assign rem3 = {rday3, lo7_3};

  // Week count and day of the week.
  logic [WEEK_W-1:0] wk6;
  logic [WDAY_W-1:0] wd6;
  logic [WEEK_W-1:0] wk16;
  logic [WDAY_W-1:0] wd16;

  s2c_cdiv #(.W(DAYS_W), .D(7), .QW(WEEK_W)) u_div_week (
    .clk (clk),
    .x   (days3),
    .q   (wk6),
    .r   (wd6)
  );

  s2c_dly #(.W(WEEK_W + WDAY_W), .N(10)) u_dly_week (
    .clk (clk),
    .d   ({wk6, wd6}),
    .q   ({wk16, wd16})
  );

  // Time of day. Seconds of the day over 60 is the quarter over 15; the
  // minute count over 60 again is its quarter over 15.
  logic [10:0]      q60_6;
  logic [3:0]       rsec6;
  logic [1:0]       lo2_6;
  logic [SEC_W-1:0] sec6;
  logic [SEC_W-1:0] sec16;

  s2c_cdiv #(.W(15), .D(15), .QW(11)) u_div_min (
    .clk (clk),
    .x   (rem3[16:2]),
    .q   (q60_6),
    .r   (rsec6)
  );

  s2c_dly #(.W(2), .N(3)) u_dly_lo2 (
    .clk (clk),
    .d   (rem3[1:0]),
    .q   (lo2_6)
  );

  assign sec6 = {rsec6, lo2_6};

  s2c_dly #(.W(SEC_W), .N(10)) u_dly_sec (
    .clk (clk),
    .d   (sec6),
    .q   (sec16)
  );

  logic [HOUR_W-1:0] hour9;
  logic [3:0]        rmin9;
  logic [1:0]        mlo9;
  logic [MIN_W-1:0]  min9;
  logic [HOUR_W-1:0] hour16;
  logic [MIN_W-1:0]  min16;

  s2c_cdiv #(.W(9), .D(15), .QW(HOUR_W)) u_div_hour (
    .clk (clk),
    .x   (q60_6[10:2]),
    .q   (hour9),
    .r   (rmin9)
  );

  s2c_dly #(.W(2), .N(3)) u_dly_mlo (
    .clk (clk),
    .d   (q60_6[1:0]),
    .q   (mlo9)
  );

  assign min9 = {rmin9, mlo9};

  s2c_dly #(.W(HOUR_W + MIN_W), .N(7)) u_dly_hm (
    .clk (clk),
    .d   ({hour9, min9}),
    .q   ({hour16, min16})
  );

  // Date. Every input lands in the era that starts at 2000-03-01, so the day
  // of era is the day count plus a fixed offset and the era term is constant.
  logic [DOE_W-1:0] doe4_r;
  logic             cent4_r;

  always_ff @(posedge clk) begin
    doe4_r  <= days3 + EPOCH_DOE;
    cent4_r <= (days3 >= CENTURY_DAYS);
  end

  logic [5:0]       q1460_7;
  logic [10:0]      r1460_7;
  logic [DOE_W-1:0] doe7;
  logic             cent7;
  logic [DOE_W-1:0] doe11;

  s2c_cdiv #(.W(DOE_W), .D(1460), .QW(6)) u_div_quad (
    .clk (clk),
    .x   (doe4_r),
    .q   (q1460_7),
    .r   (r1460_7)
  );

  s2c_dly #(.W(DOE_W + 1), .N(3)) u_dly_doe7 (
    .clk (clk),
    .d   ({doe4_r, cent4_r}),
    .q   ({doe7, cent7})
  );

  s2c_dly #(.W(DOE_W), .N(4)) u_dly_doe11 (
    .clk (clk),
    .d   (doe7),
    .q   (doe11)
  );

  // Leap-day corrected day count; over 365 it gives the year of era.
  logic [DOE_W-1:0] n8_r;

  always_ff @(posedge clk) begin
    n8_r <= doe7 - DOE_W'(q1460_7) + DOE_W'(cent7);
  end

  logic [YOE_W-1:0] yoe11;
  logic [8:0]       r365_11;
  logic [YOE_W-1:0] yoe16;

  s2c_cdiv #(.W(DOE_W), .D(365), .QW(YOE_W)) u_div_year (
    .clk (clk),
    .x   (n8_r),
    .q   (yoe11),
    .r   (r365_11)
  );

  s2c_dly #(.W(YOE_W), .N(5)) u_dly_yoe (
    .clk (clk),
    .d   (yoe11),
    .q   (yoe16)
  );

  // Day of the March-based year: the era day less the days of whole years.
  logic [DOE_W-1:0] ybase11;
  logic [DOY_W-1:0] doy12_r;

  assign ybase11 = DOE_W'(yoe11) * 16'd365 + DOE_W'(yoe11 >> 2)
                 - DOE_W'(yoe11 >= CENTURY_YEARS);

  always_ff @(posedge clk) begin
    doy12_r <= DOY_W'(doe11 - ybase11);
  end

  logic [10:0]      xm13_r;
  logic [DOY_W-1:0] doy16;

  always_ff @(posedge clk) begin
    xm13_r <= 11'(doy12_r) * 11'd5 + 11'd2;
  end

  s2c_dly #(.W(DOY_W), .N(4)) u_dly_doy (
    .clk (clk),
    .d   (doy12_r),
    .q   (doy16)
  );

  logic [MP_W-1:0] mp16;
  logic [7:0]      r153_16;

  s2c_cdiv #(.W(11), .D(153), .QW(MP_W)) u_div_month (
    .clk (clk),
    .x   (xm13_r),
    .q   (mp16),
    .r   (r153_16)
  );

  // Final assembly and output register.
  logic [YEAR_W-1:0]  year_nxt;
  logic [MONTH_W-1:0] month_nxt;
  logic [MDAY_W-1:0]  mday_nxt;
  logic               early;

  assign early     = (mp16 >= MP_JANUARY);
  assign year_nxt  = yoe16 + YEAR_W'(early);
  assign month_nxt = early ? mp16 - 4'd9 : mp16 + 4'd3;
  assign mday_nxt  = MDAY_W'(doy16 - month_start(mp16) + 9'd1);

  logic               out_valid_r;
  logic [YEAR_W-1:0]  year_r;
  logic [MONTH_W-1:0] month_r;
  logic [MDAY_W-1:0]  mday_r;
  logic [HOUR_W-1:0]  hour_r;
  logic [MIN_W-1:0]   min_r;
  logic [SEC_W-1:0]   sec_r;
  logic [WDAY_W-1:0]  wday_r;
  logic [WEEK_W-1:0]  week_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v_r[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    year_r  <= year_nxt;
    month_r <= month_nxt;
    mday_r  <= mday_nxt;
    hour_r  <= hour16;
    min_r   <= min16;
    sec_r   <= sec16;
    wday_r  <= wd16;
    week_r  <= wk16;
  end

  assign out_valid           = out_valid_r;
  assign out_year_since_2000 = year_r;
  assign out_month           = month_r;
  assign out_day_of_month    = mday_r;
  assign out_hour            = hour_r;
  assign out_minute          = min_r;
  assign out_second          = sec_r;
  assign out_weekday         = wday_r;
  assign out_week_index      = week_r;

  // Every accepted beat comes out a fixed number of edges later.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##17 out_valid)
    else $error("result beat missing at the expected latency");

  // Decoded fields stay within their calendar ranges.
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1 && out_month <= 4'd12 &&
                   out_day_of_month >= 5'd1 && out_hour <= 5'd23 &&
                   out_minute <= 6'd59 && out_second <= 6'd59 &&
                   out_weekday <= 3'd6))
    else $error("calendar field out of range");

  // Short months never reach their 31st day, and February stops at 29.
  a_month_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!((out_month == 4'd4 || out_month == 4'd6 ||
                      out_month == 4'd9 || out_month == 4'd11) &&
                     out_day_of_month > 5'd30) &&
                   !(out_month == 4'd2 && out_day_of_month > 5'd29)))
    else $error("day of month beyond month length");

endmodule

/* dv/seconds_to_calendar_fields_unit_test.sv */
`timescale 1ns / 100ps

// Self-checking bench for the seconds-to-calendar converter. Every beat taken
// on the input channel is turned into a calendar date by the bench's own
// conversion, queued, and compared field by field with the result beat that
// comes out for it. The unit never stalls and has nothing to set up, so the
// whole run is one phase: a short table of hand-picked timestamps, then a
// long stretch of random ones aimed at day, month, leap-year and century edges.
module seconds_to_calendar_fields_unit_test;

  import s2c_pkg::*;

  localparam int unsigned SECONDS_PER_DAY  = 86400;
  localparam int unsigned SECONDS_PER_HOUR = 3600;
  localparam int unsigned RANDOM_BEATS     = 1700;
  // The last stretch of random beats is sent back to back, with no gaps.
  localparam int unsigned GAPLESS_TAIL     = 300;

  // One calendar result, at the widths of the output ports.
  typedef struct packed {
    logic [YEAR_W-1:0]  year_since_2000;
    logic [MONTH_W-1:0] month;
    logic [MDAY_W-1:0]  day_of_month;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic [WDAY_W-1:0]  weekday;
    logic [WEEK_W-1:0]  week_index;
  } calendar_t;

  // An expected date waiting for its result beat, with the timestamp that
  // produced it so that a mismatch report says which input went wrong.
  typedef struct packed {
    logic [SECS_W-1:0] seconds;
    calendar_t         date;
  } pending_date_t;

  // One row of the directed table. Where the answer is plain from the
  // definition, it is typed in; every other row goes through the conversion.
  typedef struct {
    logic [SECS_W-1:0] seconds;
    bit                typed;
    calendar_t         date;
  } directed_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [SECS_W-1:0]    in_seconds_since_epoch;
  logic                 out_valid;
  logic [YEAR_W-1:0]    out_year_since_2000;
  logic [MONTH_W-1:0]   out_month;
  logic [MDAY_W-1:0]    out_day_of_month;
  logic [HOUR_W-1:0]    out_hour;
  logic [MIN_W-1:0]     out_minute;
  logic [SEC_W-1:0]     out_second;
  logic [WDAY_W-1:0]    out_weekday;
  logic [WEEK_W-1:0]    out_week_index;

  pending_date_t pending_dates[$];
  directed_row_t directed_rows[$];
  int unsigned   mismatch_count = 0;
  int unsigned   beats_sent     = 0;
  int unsigned   beats_checked  = 0;

  seconds_to_calendar_fields_unit DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_seconds_since_epoch (in_seconds_since_epoch),
    .out_valid              (out_valid),
    .out_year_since_2000    (out_year_since_2000),
    .out_month              (out_month),
    .out_day_of_month       (out_day_of_month),
    .out_hour               (out_hour),
    .out_minute             (out_minute),
    .out_second             (out_second),
    .out_weekday            (out_weekday),
    .out_week_index         (out_week_index)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Converts a timestamp to its calendar fields. The date is found by
  // counting days from 0000-03-01, so that the leap day falls at the end of
  // each counted year, and splitting that count into 400-year eras, years
  // of the era, and months of 153 days per five.
  function automatic calendar_t calendar_of(input logic [SECS_W-1:0] seconds);
    int unsigned day_count;
    int unsigned second_of_day;
    int unsigned days_from_march0;
    int unsigned era;
    int unsigned day_of_era;
    int unsigned year_of_era;
    int unsigned day_of_year;
    int unsigned march_month;
    int unsigned month_number;
    int unsigned full_year;
    calendar_t   date;
    day_count     = seconds / SECONDS_PER_DAY;
    second_of_day = seconds % SECONDS_PER_DAY;
    // 2012-01-01 is day 734808 when counted from 0000-03-01.
    days_from_march0 = day_count + 734808;
    era         = days_from_march0 / 146097;
    day_of_era  = days_from_march0 - era * 146097;
    // Drop the leap days of the era before dividing by the common year.
    year_of_era = (day_of_era - day_of_era / 1460 + day_of_era / 36524
                   - day_of_era / 146096) / 365;
    day_of_year = day_of_era - (365 * year_of_era + year_of_era / 4 - year_of_era / 100);
    march_month = (5 * day_of_year + 2) / 153;
    month_number = (march_month < 10) ? march_month + 3 : march_month - 9;
    // January and February belong to the next calendar year.
    full_year = year_of_era + era * 400 + ((month_number <= 2) ? 1 : 0);
    date.year_since_2000 = YEAR_W'(full_year - 2000);
    date.month           = MONTH_W'(month_number);
    date.day_of_month    = MDAY_W'(day_of_year - (153 * march_month + 2) / 5 + 1);
    date.hour            = HOUR_W'(second_of_day / SECONDS_PER_HOUR);
    date.minute          = MIN_W'((second_of_day / 60) % 60);
    date.second          = SEC_W'(second_of_day % 60);
    date.weekday         = WDAY_W'(day_count % 7);
    date.week_index      = WEEK_W'(day_count / 7);
    return date;
  endfunction

  // Days from the epoch to January 1st of the given year.
  function automatic int first_day_of_year(input int year);
    int days;
    days = 0;
    for (int y = 2012; y < year; y++) begin
      days += (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 366 : 365;
    end
    return days;
  endfunction

  // Picks a random timestamp. A quarter are plain 32-bit values; the rest
  // crowd around midnights, the turn of the year and the end of February in
  // every year up to the top of the range, and the last months of the range.
  function automatic logic [SECS_W-1:0] random_timestamp();
    int      day;
    int      year;
    longint  stamp;
    case ($urandom_range(0, 3))
      0: begin
        stamp = $urandom;
      end
      1: begin
        day = $urandom_range(0, 49709);
        stamp = longint'(day) * SECONDS_PER_DAY
              + ($urandom_range(0, 1) ? $urandom_range(0, 120)
                                      : SECONDS_PER_DAY - 1 - $urandom_range(0, 120));
      end
      2: begin
        // Dec 31st of the year before to March 2nd, or 1st in a leap year.
        year = $urandom_range(2012, 2148);
        day = first_day_of_year(year) + $urandom_range(0, 61) - 1;
        if (day < 0) begin
          day = 0;
        end
        stamp = longint'(day) * SECONDS_PER_DAY + $urandom_range(0, SECONDS_PER_DAY - 1);
      end
      default: begin
        stamp = longint'(32'hFFFF_FFFF) - $urandom_range(0, 200 * SECONDS_PER_DAY);
      end
    endcase
    if (stamp > longint'(32'hFFFF_FFFF)) begin
      stamp = $urandom;
    end
    return SECS_W'(stamp);
  endfunction

  // Offers one beat and returns once it has been taken. When gaps are
  // allowed, the channel may first go quiet, with junk on the data port to
  // show that it is ignored while start is low. start is left high after
  // the beat so that back-to-back beats keep it up.
  task automatic send_timestamp(input logic [SECS_W-1:0] seconds, input calendar_t date,
                                input bit allow_gap);
    int unsigned idle_cycles;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      idle_cycles = $urandom_range(1, 9);
      start                  <= 1'b0;
      in_seconds_since_epoch <= $urandom;
      repeat (idle_cycles) @(posedge clk);
    end
    start                  <= 1'b1;
    in_seconds_since_epoch <= seconds;
    do @(posedge clk); while (busy !== 1'b0);
    pending_dates.push_back('{seconds: seconds, date: date});
    beats_sent++;
  endtask

  task automatic check_field(input string name, input logic [SECS_W-1:0] seconds,
                             input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s wrong for %0d s: expected %0d, got %0d",
               $time, name, seconds, want, got);
      mismatch_count++;
    end
  endtask

  // Result side. The receiver cannot stall, so every cycle with out_valid
  // high is a beat; it is matched against the oldest queued date. Outputs are
  // read at the rising edge, before the unit's registers move.
  always @(posedge clk) begin : result_checker
    pending_date_t oldest;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: result beat with no timestamp waiting for it", $time);
        mismatch_count++;
      end else begin
        oldest = pending_dates.pop_front();
        beats_checked++;
        check_field("year_since_2000", oldest.seconds, oldest.date.year_since_2000,
                    out_year_since_2000);
        check_field("month", oldest.seconds, oldest.date.month, out_month);
        check_field("day_of_month", oldest.seconds, oldest.date.day_of_month,
                    out_day_of_month);
        check_field("hour", oldest.seconds, oldest.date.hour, out_hour);
        check_field("minute", oldest.seconds, oldest.date.minute, out_minute);
        check_field("second", oldest.seconds, oldest.date.second, out_second);
        check_field("weekday", oldest.seconds, oldest.date.weekday, out_weekday);
        check_field("week_index", oldest.seconds, oldest.date.week_index, out_week_index);
      end
    end
  end

  initial begin
    calendar_t date;
    logic [SECS_W-1:0] seconds;

    rst_n                  = 1'b0;
    start                  = 1'b0;
    in_seconds_since_epoch = '0;

    // Directed table. The epoch itself and the top of the range are typed
    // in: 2012-01-01 00:00:00, a Sunday in week 0, and 2148-02-07 06:28:15,
    // a Wednesday in week 7101.
    directed_rows.push_back('{32'd0, 1'b1,
                              '{8'd12, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 3'd0, 13'd0}});
    // Edges of the second, minute and hour counters within the first day.
    directed_rows.push_back('{32'd1, 1'b0, '0});
    directed_rows.push_back('{32'd59, 1'b0, '0});
    directed_rows.push_back('{32'd60, 1'b0, '0});
    directed_rows.push_back('{32'd3599, 1'b0, '0});
    directed_rows.push_back('{32'd3600, 1'b0, '0});
    // Midnight: every day has exactly 86400 seconds, with no leap second.
    directed_rows.push_back('{32'd86399, 1'b0, '0});
    directed_rows.push_back('{32'd86400, 1'b0, '0});
    // The leap day of 2012 and the days around it.
    directed_rows.push_back('{32'd5011199, 1'b0, '0});
    directed_rows.push_back('{32'd5097600, 1'b0, '0});
    directed_rows.push_back('{32'd5183999, 1'b0, '0});
    directed_rows.push_back('{32'd5184000, 1'b0, '0});
    // New Year 2013, after the 366 days of 2012.
    directed_rows.push_back('{32'd31622399, 1'b0, '0});
    directed_rows.push_back('{32'd31622400, 1'b0, '0});
    // 2100 is a century year and has no February 29th.
    directed_rows.push_back('{32'd2782166399, 1'b0, '0});
    directed_rows.push_back('{32'd2782166400, 1'b0, '0});
    // Alternating and single-bit patterns across the input word.
    directed_rows.push_back('{32'h7FFF_FFFF, 1'b0, '0});
    directed_rows.push_back('{32'h8000_0000, 1'b0, '0});
    directed_rows.push_back('{32'hAAAA_AAAA, 1'b0, '0});
    directed_rows.push_back('{32'h5555_5555, 1'b0, '0});
    directed_rows.push_back('{32'hFFFF_FFFE, 1'b0, '0});
    directed_rows.push_back('{32'hFFFF_FFFF, 1'b1,
                              '{8'd148, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15, 3'd3, 13'd7101}});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      date = directed_rows[i].typed ? directed_rows[i].date
                                    : calendar_of(directed_rows[i].seconds);
      send_timestamp(directed_rows[i].seconds, date, 1'b1);
    end

    // Random part; the tail runs at full rate to keep the pipeline packed.
    for (int unsigned n = 0; n < RANDOM_BEATS; n++) begin
      seconds = random_timestamp();
      send_timestamp(seconds, calendar_of(seconds), n < RANDOM_BEATS - GAPLESS_TAIL);
    end
    start <= 1'b0;

    // Drain: every date must come back, then the bench waits on to catch any
    // stray beat.
    wait (pending_dates.size() == 0);
    repeat (2 * PIPE_DEPTH + 4) @(posedge clk);

    $display("Converted %0d timestamps (%0d from the table, %0d random), checked %0d dates,",
             beats_sent, directed_rows.size(), RANDOM_BEATS, beats_checked);
    $display("found %0d field mismatches.", mismatch_count);
    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("seconds_to_calendar_fields_unit_test passed");
    end else begin
      $display("seconds_to_calendar_fields_unit_test failed");
    end
    $finish;
  end

  // Watchdog. It allows at least ten times as long as a correct run takes
  // with the longest gaps on every beat.
  initial begin
    #2_000_000;
    $display("Timed out with %0d dates still pending.", pending_dates.size());
    $display("seconds_to_calendar_fields_unit_test failed");
    $finish;
  end

endmodule
